### design/ewq_pkg.sv
package ewq_pkg;

    localparam int EVENT_SLOTS = 16;
    localparam int PROC_COUNT  = 64;
    localparam int SLOT_W      = $clog2(EVENT_SLOTS);
    localparam int PID_W       = $clog2(PROC_COUNT);
    localparam int PTR_W       = PID_W + 1;
    localparam int STEP_W      = PID_W + 1;

    // A queue pointer equal to the process count means "no process".
    localparam logic [PTR_W-1:0] PTR_NIL = PTR_W'(PROC_COUNT);

    localparam logic signed [31:0] VAL_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] VAL_MIN = 32'sh8000_0000;

    typedef enum logic [3:0] {
        MODE_CREATE  = 4'd0,
        MODE_DELETE  = 4'd1,
        MODE_LINK    = 4'd2,
        MODE_UNLINK  = 4'd3,
        MODE_WAIT    = 4'd4,
        MODE_SIGNAL  = 4'd5,
        MODE_PULSE   = 4'd6,
        MODE_SET     = 4'd7,
        MODE_SET_REL = 4'd8,
        MODE_READ    = 4'd9,
        MODE_DEQUEUE = 4'd10
    } mode_t;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_NOT_YET   = 3'd1,
        ST_BAD_ID    = 3'd2,
        ST_BUSY      = 3'd3,
        ST_FULL      = 3'd4,
        ST_NOT_FOUND = 3'd5
    } status_t;

    typedef struct packed {
        logic [3:0]          mode;
        logic [3:0]          event_slot;
        logic [5:0]          process;
        logic signed [31:0]  value;
        logic signed [31:0]  upper_value;
        logic signed [15:0]  wait_increment;
        logic signed [15:0]  signal_increment;
        logic                all_waiters;
    } in_word_t;

    typedef struct packed {
        logic [2:0]          status;
        logic signed [31:0]  result_value;
        logic [3:0]          result_slot;
    } out_word_t;

    typedef struct packed {
        logic                waiting;
        logic [SLOT_W-1:0]   wait_slot;
        logic signed [31:0]  range_low;
        logic signed [31:0]  range_high;
        logic [PTR_W-1:0]    next;
        logic                woken;
        logic signed [31:0]  wake_value;
        logic                wake_error;
    } proc_row_t;

    typedef struct packed {
        logic                en;
        logic [PID_W-1:0]    addr;
        proc_row_t           data;
    } ram_wr_t;

    localparam proc_row_t PROC_ROW_RESET = '{
        waiting:    1'b0,
        wait_slot:  '0,
        range_low:  '0,
        range_high: '0,
        next:       PTR_NIL,
        woken:      1'b0,
        wake_value: '0,
        wake_error: 1'b0
    };

    function automatic logic signed [31:0] sat_add(input logic signed [31:0] a,
                                                   input logic signed [31:0] b);
        logic signed [32:0] s;
        s = {a[31], a} + {b[31], b};
        if (s[32] != s[31])
        begin
            return s[32] ? VAL_MIN : VAL_MAX;
        end
        return s[31:0];
    endfunction

    function automatic logic signed [31:0] sext16(input logic signed [15:0] x);
        return {{16{x[15]}}, x};
    endfunction

endpackage

### design/event_wait_queue_unit.sv
// Create, delete of a busy or free slot, link, unlink and read go straight to the result;
// wait and dequeue check the process row, then may unlink it from a queue and enqueue it.
// Signal-style operations and delete walk the event's queue one entry at a time through
// the process table, visiting at most PROC_COUNT entries.
// Throughput: one word at a time; busy is high until the result strobe has been given.
// Reset clears all events and process states at once; the result cannot be stalled.
module event_wait_queue_unit import ewq_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    input  in_word_t  cmd,
    output logic      busy,
    output logic      done,
    output out_word_t rsp
);

    typedef enum logic [13:0] {
        S_IDLE     = 14'b00000000000001,
        S_PID_CHK  = 14'b00000000000010,
        S_DQ_RD    = 14'b00000000000100,
        S_DQ_CHK   = 14'b00000000001000,
        S_DQ_FIN   = 14'b00000000010000,
        S_ENQ      = 14'b00000000100000,
        S_ENQ_TAIL = 14'b00000001000000,
        S_SRCH_RD  = 14'b00000010000000,
        S_SRCH_CHK = 14'b00000100000000,
        S_SRCH_FIX = 14'b00001000000000,
        S_SRCH_END = 14'b00010000000000,
        S_DEL_RD   = 14'b00100000000000,
        S_DEL_CHK  = 14'b01000000000000,
        S_DONE     = 14'b10000000000000
    } state_t;

    state_t               state_reg, state_next;
    in_word_t             cmd_reg, cmd_next;
    status_t              status_reg, status_next;
    logic signed [31:0]   rval_reg, rval_next;
    logic [SLOT_W-1:0]    rslot_reg, rslot_next;

    logic [EVENT_SLOTS-1:0] in_use_reg, in_use_next;
    logic signed [31:0]   evt_value_reg [EVENT_SLOTS];
    logic signed [31:0]   evt_value_next [EVENT_SLOTS];
    logic signed [15:0]   evt_winc_reg [EVENT_SLOTS];
    logic signed [15:0]   evt_winc_next [EVENT_SLOTS];
    logic signed [15:0]   evt_sinc_reg [EVENT_SLOTS];
    logic signed [15:0]   evt_sinc_next [EVENT_SLOTS];
    logic [15:0]          evt_link_reg [EVENT_SLOTS];
    logic [15:0]          evt_link_next [EVENT_SLOTS];
    logic [PTR_W-1:0]     head_reg [EVENT_SLOTS];
    logic [PTR_W-1:0]     head_next [EVENT_SLOTS];
    logic [PTR_W-1:0]     tail_reg [EVENT_SLOTS];
    logic [PTR_W-1:0]     tail_next [EVENT_SLOTS];

    proc_row_t            pid_row_reg, pid_row_next;
    proc_row_t            prev_row_reg, prev_row_next;
    proc_row_t            cur_row_reg, cur_row_next;
    logic [PTR_W-1:0]     walk_ptr_reg, walk_ptr_next;
    logic [PTR_W-1:0]     prev_ptr_reg, prev_ptr_next;
    logic [PTR_W-1:0]     hit_ptr_reg, hit_ptr_next;
    logic [STEP_W-1:0]    steps_reg, steps_next;
    logic [SLOT_W-1:0]    dq_slot_reg, dq_slot_next;
    logic                 enq_after_reg, enq_after_next;
    logic                 stop_reg, stop_next;
    logic signed [31:0]   cur_val_reg, cur_val_next;
    logic signed [31:0]   old_val_reg, old_val_next;

    ram_wr_t              ram_wr;
    logic [PID_W-1:0]     ram_rd_addr;
    proc_row_t            ram_rd;

    logic                 free_found;
    logic [SLOT_W-1:0]    free_idx;
    logic [SLOT_W-1:0]    s_in;
    logic [SLOT_W-1:0]    s;
    logic [PTR_W-1:0]     pid_ptr;
    logic                 live_in;
    logic                 live;
    logic                 queued;
    logic                 stale;
    logic                 hit;
    logic                 walk_end;
    proc_row_t            row_mod;
    logic signed [31:0]   ev;
    logic signed [31:0]   ev_inc;

    ewq_proc_ram u_proc_ram
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (ram_wr),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd)
    );

    always_comb
    begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int k = EVENT_SLOTS - 1; k >= 0; k--)
        begin
            if (!in_use_reg[k])
            begin
                free_found = 1'b1;
                free_idx   = SLOT_W'(k);
            end
        end
    end

    assign s_in     = cmd.event_slot;
    assign s        = cmd_reg.event_slot;
    assign pid_ptr  = PTR_W'(cmd_reg.process);
    assign live_in  = in_use_reg[s_in];
    assign live     = in_use_reg[s];
    assign queued   = ram_rd.waiting && (ram_rd.wait_slot == s);
    assign stale    = !ram_rd.waiting || (ram_rd.wait_slot != s);
    assign hit      = !stale && ($signed(cur_val_reg) >= $signed(ram_rd.range_low))
                      && ($signed(cur_val_reg) <= $signed(ram_rd.range_high));
    assign walk_end = (walk_ptr_reg >= PTR_NIL) || (steps_reg == STEP_W'(PROC_COUNT));
    assign ev       = evt_value_reg[s];
    assign ev_inc   = sat_add(ev, sext16(evt_winc_reg[s]));

    always_comb
    begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        status_next    = status_reg;
        rval_next      = rval_reg;
        rslot_next     = rslot_reg;
        in_use_next    = in_use_reg;
        evt_value_next = evt_value_reg;
        evt_winc_next  = evt_winc_reg;
        evt_sinc_next  = evt_sinc_reg;
        evt_link_next  = evt_link_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        pid_row_next   = pid_row_reg;
        prev_row_next  = prev_row_reg;
        cur_row_next   = cur_row_reg;
        walk_ptr_next  = walk_ptr_reg;
        prev_ptr_next  = prev_ptr_reg;
        hit_ptr_next   = hit_ptr_reg;
        steps_next     = steps_reg;
        dq_slot_next   = dq_slot_reg;
        enq_after_next = enq_after_reg;
        stop_next      = stop_reg;
        cur_val_next   = cur_val_reg;
        old_val_next   = old_val_reg;
        ram_wr         = '{en: 1'b0, addr: '0, data: PROC_ROW_RESET};
        ram_rd_addr    = walk_ptr_reg[PID_W-1:0];
        row_mod        = ram_rd;

        unique case (state_reg)
            S_IDLE:
            begin
                ram_rd_addr = cmd.process;
                if (start)
                begin
                    cmd_next      = cmd;
                    status_next   = ST_OK;
                    rval_next     = '0;
                    rslot_next    = '0;
                    steps_next    = '0;
                    prev_ptr_next = PTR_NIL;
                    walk_ptr_next = head_reg[s_in];
                    stop_next     = 1'b0;
                    state_next    = S_DONE;
                    case (cmd.mode)
                        MODE_CREATE:
                        begin
                            status_next = ST_FULL;
                            if (free_found)
                            begin
                                in_use_next[free_idx]    = 1'b1;
                                evt_value_next[free_idx] = cmd.value;
                                evt_winc_next[free_idx]  = cmd.wait_increment;
                                evt_sinc_next[free_idx]  = cmd.signal_increment;
                                evt_link_next[free_idx]  = 16'd1;
                                head_next[free_idx]      = PTR_NIL;
                                tail_next[free_idx]      = PTR_NIL;
                                rslot_next               = free_idx;
                                status_next              = ST_OK;
                            end
                        end
                        MODE_DELETE:
                        begin
                            if (!live_in)
                            begin
                                status_next = ST_NOT_FOUND;
                            end
                            else if (evt_link_reg[s_in] != 16'd0)
                            begin
                                status_next = ST_BUSY;
                            end
                            else
                            begin
                                state_next = S_DEL_RD;
                            end
                        end
                        MODE_LINK:
                        begin
                            if (!live_in)
                            begin
                                status_next = ST_NOT_FOUND;
                            end
                            else if (evt_link_reg[s_in] != 16'hFFFF)
                            begin
                                evt_link_next[s_in] = evt_link_reg[s_in] + 16'd1;
                            end
                        end
                        MODE_UNLINK:
                        begin
                            if (!live_in)
                            begin
                                status_next = ST_BAD_ID;
                            end
                            else if (evt_link_reg[s_in] != 16'd0)
                            begin
                                evt_link_next[s_in] = evt_link_reg[s_in] - 16'd1;
                            end
                        end
                        MODE_WAIT, MODE_DEQUEUE:
                        begin
                            state_next = S_PID_CHK;
                        end
                        MODE_SIGNAL, MODE_PULSE, MODE_SET, MODE_SET_REL:
                        begin
                            if (!live_in)
                            begin
                                status_next = ST_BAD_ID;
                            end
                            else
                            begin
                                state_next   = S_SRCH_RD;
                                old_val_next = evt_value_reg[s_in];
                                if (cmd.mode == MODE_SIGNAL)
                                begin
                                    cur_val_next = sat_add(evt_value_reg[s_in],
                                                           sext16(evt_sinc_reg[s_in]));
                                end
                                else if (cmd.mode == MODE_SET_REL)
                                begin
                                    cur_val_next = sat_add(evt_value_reg[s_in], cmd.value);
                                end
                                else
                                begin
                                    cur_val_next = cmd.value;
                                end
                                if (cmd.mode == MODE_SET || cmd.mode == MODE_SET_REL)
                                begin
                                    rval_next = evt_value_reg[s_in];
                                end
                            end
                        end
                        MODE_READ:
                        begin
                            if (!live_in)
                            begin
                                status_next = ST_BAD_ID;
                            end
                            else
                            begin
                                rval_next = evt_value_reg[s_in];
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            S_PID_CHK:
            begin
                pid_row_next   = ram_rd;
                enq_after_next = 1'b0;
                state_next     = S_DONE;
                if (cmd_reg.mode == MODE_WAIT && queued && ram_rd.woken)
                begin
                    row_mod.waiting = 1'b0;
                    row_mod.woken   = 1'b0;
                    row_mod.next    = PTR_NIL;
                    ram_wr          = '{en: 1'b1, addr: cmd_reg.process, data: row_mod};
                    rval_next       = ram_rd.wake_value;
                    status_next     = ram_rd.wake_error ? ST_BAD_ID : ST_OK;
                end
                else if (cmd_reg.mode == MODE_WAIT && live && queued)
                begin
                    status_next = ST_NOT_YET;
                end
                else if (cmd_reg.mode == MODE_WAIT && live
                         && (ev >= cmd_reg.value) && (ev <= cmd_reg.upper_value))
                begin
                    evt_value_next[s] = ev_inc;
                    rval_next         = ev_inc;
                end
                else
                begin
                    // Dequeue the process first; a wait on a live event then joins this queue.
                    if (cmd_reg.mode == MODE_WAIT)
                    begin
                        enq_after_next = live;
                        status_next    = live ? ST_NOT_YET : ST_BAD_ID;
                    end
                    if (!ram_rd.waiting)
                    begin
                        row_mod.woken = 1'b0;
                        ram_wr        = '{en: 1'b1, addr: cmd_reg.process, data: row_mod};
                        state_next    = (cmd_reg.mode == MODE_WAIT && live) ? S_ENQ : S_DONE;
                    end
                    else if (in_use_reg[ram_rd.wait_slot])
                    begin
                        dq_slot_next  = ram_rd.wait_slot;
                        walk_ptr_next = head_reg[ram_rd.wait_slot];
                        prev_ptr_next = PTR_NIL;
                        steps_next    = '0;
                        state_next    = S_DQ_RD;
                    end
                    else
                    begin
                        state_next = S_DQ_FIN;
                    end
                end
            end

            S_DQ_RD:
            begin
                state_next = walk_end ? S_DQ_FIN : S_DQ_CHK;
            end

            S_DQ_CHK:
            begin
                if (walk_ptr_reg == pid_ptr)
                begin
                    if (prev_ptr_reg >= PTR_NIL)
                    begin
                        head_next[dq_slot_reg] = ram_rd.next;
                    end
                    else
                    begin
                        row_mod      = prev_row_reg;
                        row_mod.next = ram_rd.next;
                        ram_wr       = '{en: 1'b1, addr: prev_ptr_reg[PID_W-1:0],
                                         data: row_mod};
                    end
                    if (tail_reg[dq_slot_reg] == pid_ptr)
                    begin
                        tail_next[dq_slot_reg] = prev_ptr_reg;
                    end
                    state_next = S_DQ_FIN;
                end
                else
                begin
                    prev_ptr_next = walk_ptr_reg;
                    prev_row_next = ram_rd;
                    walk_ptr_next = ram_rd.next;
                    steps_next    = steps_reg + STEP_W'(1);
                    state_next    = S_DQ_RD;
                end
            end

            S_DQ_FIN:
            begin
                row_mod         = pid_row_reg;
                row_mod.waiting = 1'b0;
                row_mod.woken   = 1'b0;
                row_mod.next    = PTR_NIL;
                ram_wr          = '{en: 1'b1, addr: cmd_reg.process, data: row_mod};
                state_next      = enq_after_reg ? S_ENQ : S_DONE;
            end

            S_ENQ:
            begin
                row_mod.waiting    = 1'b1;
                row_mod.wait_slot  = s;
                row_mod.range_low  = cmd_reg.value;
                row_mod.range_high = cmd_reg.upper_value;
                row_mod.next       = (tail_reg[s] == pid_ptr) ? pid_ptr : PTR_NIL;
                row_mod.woken      = 1'b0;
                row_mod.wake_value = '0;
                row_mod.wake_error = 1'b0;
                ram_wr             = '{en: 1'b1, addr: cmd_reg.process, data: row_mod};
                ram_rd_addr        = tail_reg[s][PID_W-1:0];
                if (tail_reg[s] < PTR_NIL && tail_reg[s] != pid_ptr)
                begin
                    state_next = S_ENQ_TAIL;
                end
                else
                begin
                    if (tail_reg[s] >= PTR_NIL)
                    begin
                        head_next[s] = pid_ptr;
                    end
                    tail_next[s] = pid_ptr;
                    status_next  = ST_NOT_YET;
                    state_next   = S_DONE;
                end
            end

            S_ENQ_TAIL:
            begin
                row_mod.next = pid_ptr;
                ram_wr       = '{en: 1'b1, addr: tail_reg[s][PID_W-1:0], data: row_mod};
                tail_next[s] = pid_ptr;
                status_next  = ST_NOT_YET;
                state_next   = S_DONE;
            end

            S_SRCH_RD:
            begin
                state_next = walk_end ? S_SRCH_END : S_SRCH_CHK;
            end

            S_SRCH_CHK:
            begin
                if (stale || hit)
                begin
                    row_mod.next = PTR_NIL;
                    if (hit)
                    begin
                        row_mod.wake_value = cur_val_reg;
                        row_mod.wake_error = 1'b0;
                        row_mod.woken      = 1'b1;
                        cur_val_next = sat_add(cur_val_reg, sext16(evt_winc_reg[s]));
                    end
                    if (tail_reg[s] == walk_ptr_reg)
                    begin
                        tail_next[s] = prev_ptr_reg;
                    end
                    walk_ptr_next = ram_rd.next;
                    steps_next    = steps_reg + STEP_W'(1);
                    if (prev_ptr_reg >= PTR_NIL)
                    begin
                        head_next[s] = ram_rd.next;
                        ram_wr       = '{en: 1'b1, addr: walk_ptr_reg[PID_W-1:0],
                                         data: row_mod};
                        state_next   = (hit && !cmd_reg.all_waiters) ? S_SRCH_END : S_SRCH_RD;
                    end
                    else
                    begin
                        // Relink the predecessor now, retire this entry next cycle.
                        prev_row_next      = prev_row_reg;
                        prev_row_next.next = ram_rd.next;
                        ram_wr       = '{en: 1'b1, addr: prev_ptr_reg[PID_W-1:0],
                                         data: prev_row_next};
                        cur_row_next = row_mod;
                        hit_ptr_next = walk_ptr_reg;
                        stop_next    = hit && !cmd_reg.all_waiters;
                        state_next   = S_SRCH_FIX;
                    end
                end
                else
                begin
                    prev_ptr_next = walk_ptr_reg;
                    prev_row_next = ram_rd;
                    walk_ptr_next = ram_rd.next;
                    steps_next    = steps_reg + STEP_W'(1);
                    state_next    = S_SRCH_RD;
                end
            end

            S_SRCH_FIX:
            begin
                ram_wr     = '{en: 1'b1, addr: hit_ptr_reg[PID_W-1:0], data: cur_row_reg};
                state_next = stop_reg ? S_SRCH_END : S_SRCH_RD;
            end

            S_SRCH_END:
            begin
                evt_value_next[s] = (cmd_reg.mode == MODE_PULSE) ? old_val_reg : cur_val_reg;
                state_next        = S_DONE;
            end

            S_DEL_RD:
            begin
                ram_rd_addr = head_reg[s][PID_W-1:0];
                if (head_reg[s] >= PTR_NIL || steps_reg == STEP_W'(PROC_COUNT))
                begin
                    in_use_next[s] = 1'b0;
                    head_next[s]   = PTR_NIL;
                    tail_next[s]   = PTR_NIL;
                    state_next     = S_DONE;
                end
                else
                begin
                    state_next = S_DEL_CHK;
                end
            end

            S_DEL_CHK:
            begin
                if (queued)
                begin
                    row_mod.wake_value = '0;
                    row_mod.wake_error = 1'b1;
                    row_mod.woken      = 1'b1;
                    row_mod.waiting    = 1'b0;
                end
                row_mod.next = PTR_NIL;
                ram_wr       = '{en: 1'b1, addr: head_reg[s][PID_W-1:0], data: row_mod};
                head_next[s] = ram_rd.next;
                if (tail_reg[s] == head_reg[s])
                begin
                    tail_next[s] = PTR_NIL;
                end
                steps_next = steps_reg + STEP_W'(1);
                state_next = S_DEL_RD;
            end

            S_DONE:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            in_use_reg <= '0;
            for (int k = 0; k < EVENT_SLOTS; k++)
            begin
                head_reg[k] <= PTR_NIL;
                tail_reg[k] <= PTR_NIL;
            end
        end
        else
        begin
            state_reg  <= state_next;
            in_use_reg <= in_use_next;
            head_reg   <= head_next;
            tail_reg   <= tail_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg       <= cmd_next;
        status_reg    <= status_next;
        rval_reg      <= rval_next;
        rslot_reg     <= rslot_next;
        evt_value_reg <= evt_value_next;
        evt_winc_reg  <= evt_winc_next;
        evt_sinc_reg  <= evt_sinc_next;
        evt_link_reg  <= evt_link_next;
        pid_row_reg   <= pid_row_next;
        prev_row_reg  <= prev_row_next;
        cur_row_reg   <= cur_row_next;
        walk_ptr_reg  <= walk_ptr_next;
        prev_ptr_reg  <= prev_ptr_next;
        hit_ptr_reg   <= hit_ptr_next;
        steps_reg     <= steps_next;
        dq_slot_reg   <= dq_slot_next;
        enq_after_reg <= enq_after_next;
        stop_reg      <= stop_next;
        cur_val_reg   <= cur_val_next;
        old_val_reg   <= old_val_next;
    end

    assign busy = (state_reg != S_IDLE);
    assign done = (state_reg == S_DONE);
    assign rsp  = '{status: status_reg, result_value: rval_reg, result_slot: rslot_reg};

    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe held longer than one cycle");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted word did not raise busy");

    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> busy)
        else $error("result strobe while idle");

    a_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> (steps_reg <= STEP_W'(PROC_COUNT)))
        else $error("queue walk ran past the process count");

endmodule

### design/ewq_proc_ram.sv
module ewq_proc_ram import ewq_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  ram_wr_t          wr,
    input  logic [PID_W-1:0] rd_addr,
    output proc_row_t        rd_data
);

    proc_row_t              mem [PROC_COUNT];
    proc_row_t              row_reg;
    logic                   row_valid_reg;
    logic [PROC_COUNT-1:0]  valid_reg;
    logic                   fwd;

    assign fwd = wr.en && (wr.addr == rd_addr);

    // A same-cycle write to the read address is forwarded to the read data.
    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
        if (fwd)
        begin
            row_reg <= wr.data;
        end
        else
        begin
            row_reg <= mem[rd_addr];
        end
    end

    // Rows never written since reset read as the reset row.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            row_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr.en)
            begin
                valid_reg[wr.addr] <= 1'b1;
            end
            row_valid_reg <= valid_reg[rd_addr] | fwd;
        end
    end

    assign rd_data = row_valid_reg ? row_reg : PROC_ROW_RESET;

endmodule
